// ===== rtl/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants for the slab object allocator
// Request kinds, result status codes, controller states and width helpers.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int DEF_CHUNK_BYTES = 4096;
  localparam int DEF_NUM_CHUNKS  = 64;
  localparam int DEF_MAX_SLOTS   = 256;

  localparam int OBJ_W    = 12;
  localparam int OFFSET_W = 18;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [OBJ_W-1:0] OBJ_SIZE_MIN   = 12'd16;
  localparam logic [OBJ_W-1:0] OBJ_SIZE_MAX   = 12'd2048;
  localparam logic [OBJ_W-1:0] OBJ_SIZE_RESET = 12'd16;

  // register word index on the config port
  localparam logic [ADDR_W-3:0] REG_OBJECT_SIZE = 1'b0;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_ROOM,
    ST_POP,
    ST_MUL,
    ST_OUT
  } state_t;

  // index width, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== rtl/slab_object_allocator.sv =====
// ----------------------------------------------------------------------------
// slab_object_allocator: fixed-size object allocator over a chunked pool
// Per-chunk LIFO free lists in block RAM, lowest-partial-chunk allocation.
// ----------------------------------------------------------------------------
// One request at a time. A request is taken when start is high and busy is
// low; its result shows on the result ports for a single cycle with done high
// and cannot be held off, so the receiver must take it then. A free reads the
// chunk word, then writes it back if valid. An allocate reports out of memory
// when no chunk is partial and none can be opened; otherwise it opens a new
// chunk, takes a never-used slot or pops a returned slot (reading its link
// from the slot RAM); a stale partial chunk after an object_size change sends
// it back to the scan. The state lives in two single-port-read RAMs (chunk
// head/fresh words and slot links) with registered reads. After reset no RAM
// clearing is done. A write to object_size recomputes the slots per chunk
// with a bit-serial divider, holding busy until the divider has finished.
// ----------------------------------------------------------------------------
module slab_object_allocator #(
  parameter int CHUNK_BYTES = soa_pkg::DEF_CHUNK_BYTES,
  parameter int NUM_CHUNKS  = soa_pkg::DEF_NUM_CHUNKS,
  parameter int MAX_SLOTS   = soa_pkg::DEF_MAX_SLOTS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // config port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [soa_pkg::ADDR_W-1:0]              paddr,
  input  logic [soa_pkg::DATA_W-1:0]              pwdata,
  output logic [soa_pkg::DATA_W-1:0]              prdata,
  output logic                                    pready,
  // request
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    kind,
  input  logic [soa_pkg::idx_w(NUM_CHUNKS)-1:0]   chunk_index,
  input  logic [soa_pkg::idx_w(MAX_SLOTS)-1:0]    slot_index,
  // result
  output logic                                    done,
  output logic [soa_pkg::STATUS_W-1:0]            status,
  output logic [soa_pkg::idx_w(NUM_CHUNKS)-1:0]   got_chunk,
  output logic [soa_pkg::idx_w(MAX_SLOTS)-1:0]    got_slot,
  output logic [soa_pkg::OFFSET_W-1:0]            byte_offset
);
  import soa_pkg::*;

  localparam int CHUNK_W = idx_w(NUM_CHUNKS);
  localparam int SW      = idx_w(MAX_SLOTS);
  localparam int NW      = $clog2(MAX_SLOTS + 1);
  localparam int COUNT_W = $clog2(NUM_CHUNKS + 1);
  localparam int LINK_W  = idx_w(NUM_CHUNKS * MAX_SLOTS);
  localparam int CW_W    = SW + NW;
  localparam int PROD_W  = SW + OBJ_W;

  // ---------------- config ----------------
  logic [OBJ_W-1:0] object_size;
  logic [OBJ_W-1:0] eff;
  logic             cfg_wr;
  logic             div_go;
  logic             div_busy;
  logic [NW-1:0]    n_slots;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_OBJECT_SIZE);
  assign prdata = (paddr[ADDR_W-1:2] == REG_OBJECT_SIZE) ?
                  DATA_W'(object_size) : '0;

  always_comb begin
    if (object_size < OBJ_SIZE_MIN) begin
      eff = OBJ_SIZE_MIN;
    end else if (object_size > OBJ_SIZE_MAX) begin
      eff = OBJ_SIZE_MAX;
    end else begin
      eff = object_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_size <= OBJ_SIZE_RESET;
      div_go      <= 1'b0;
    end else begin
      div_go <= cfg_wr;
      if (cfg_wr) begin
        object_size <= pwdata[OBJ_W-1:0];
      end
    end
  end

  soa_slot_div #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .divisor (eff),
    .busy    (div_busy),
    .slots   (n_slots)
  );

  // ---------------- state ----------------
  state_t               state;
  state_t               state_next;
  logic [NUM_CHUNKS-1:0] partial_map;
  logic [COUNT_W-1:0]   chunks_open;
  logic [CHUNK_W-1:0]   req_chunk;
  logic [SW-1:0]        req_slot;
  logic [CHUNK_W-1:0]   pick;
  logic [SW-1:0]        slot_r;
  logic [PROD_W-1:0]    prod;

  // chunk word: {free-list head, next fresh slot}
  logic [CW_W-1:0]      chunk_mem [NUM_CHUNKS];
  logic [CW_W-1:0]      chunk_rd;
  logic                 cm_re;
  logic [CHUNK_W-1:0]   cm_raddr;
  logic                 cm_we;
  logic [CHUNK_W-1:0]   cm_waddr;
  logic [CW_W-1:0]      cm_wdata;

  logic [SW-1:0]        link_mem [NUM_CHUNKS * MAX_SLOTS];
  logic [SW-1:0]        link_rd;
  logic                 lm_re;
  logic [LINK_W-1:0]    lm_raddr;
  logic                 lm_we;
  logic [LINK_W-1:0]    lm_waddr;
  logic [SW-1:0]        lm_wdata;

  always_ff @(posedge clk) begin
    if (cm_we) begin
      chunk_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      chunk_rd <= chunk_mem[cm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      link_mem[lm_waddr] <= lm_wdata;
    end
    if (lm_re) begin
      link_rd <= link_mem[lm_raddr];
    end
  end

  function automatic logic [LINK_W-1:0] link_addr(input logic [CHUNK_W-1:0] c,
                                                  input logic [SW-1:0] s);
    return LINK_W'(32'(c) * 32'(MAX_SLOTS) + 32'(s));
  endfunction

  // ---------------- decode ----------------
  logic [SW-1:0]      head_rd;
  logic [NW-1:0]      fresh_rd;
  logic [NW-1:0]      fresh_inc;
  logic               accept;
  logic               free_ok;
  logic               any_partial;
  logic [CHUNK_W-1:0] low_pick;
  logic               can_open;
  logic [CHUNK_W-1:0] open_chunk;
  logic               room;
  logic               keep_fresh;
  logic               keep_pop;
  logic               keep_open;
  logic [31:0]        off_sum;

  assign head_rd    = chunk_rd[CW_W-1:NW];
  assign fresh_rd   = chunk_rd[NW-1:0];
  assign fresh_inc  = fresh_rd + 1'b1;
  assign busy       = (state != ST_IDLE) || div_go || div_busy;
  assign accept     = start && !busy;
  assign free_ok    = (COUNT_W'(req_chunk) < chunks_open) && (req_slot != '0) &&
                      (NW'(req_slot) < n_slots) && (NW'(req_slot) < fresh_rd);
  assign any_partial = |partial_map;
  assign can_open   = (chunks_open < COUNT_W'(NUM_CHUNKS)) && (n_slots >= NW'(2));
  assign open_chunk = chunks_open[CHUNK_W-1:0];
  assign room       = (head_rd != '0) || (fresh_rd < n_slots);
  assign keep_fresh = fresh_inc < n_slots;
  assign keep_pop   = (link_rd != '0) || (fresh_rd < n_slots);
  assign keep_open  = NW'(2) < n_slots;
  assign off_sum    = 32'(pick) * 32'(CHUNK_BYTES) + 32'(prod);

  // lowest set partial bit
  always_comb begin
    low_pick = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (partial_map[i]) begin
        low_pick = CHUNK_W'(i);
      end
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_FREE) ? ST_FREE : ST_SCAN;
        end
      end
      ST_FREE: state_next = ST_IDLE;
      ST_SCAN: begin
        if (any_partial) begin
          state_next = ST_ROOM;
        end else if (can_open) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ROOM: begin
        if (!room) begin
          state_next = ST_SCAN;   // stale bit after a size change
        end else if (head_rd != '0) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_POP:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- memory control ----------------
  always_comb begin
    cm_re    = 1'b0;
    cm_raddr = low_pick;
    cm_we    = 1'b0;
    cm_waddr = pick;
    cm_wdata = '0;
    lm_re    = 1'b0;
    lm_raddr = link_addr(pick, head_rd);
    lm_we    = 1'b0;
    lm_waddr = link_addr(req_chunk, req_slot);
    lm_wdata = head_rd;
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_FREE) begin
          cm_re    = 1'b1;
          cm_raddr = chunk_index;
        end
      end
      ST_FREE: begin
        if (free_ok) begin
          lm_we    = 1'b1;
          cm_we    = 1'b1;
          cm_waddr = req_chunk;
          cm_wdata = {req_slot, fresh_rd};
        end
      end
      ST_SCAN: begin
        if (any_partial) begin
          cm_re = 1'b1;
        end else if (can_open) begin
          cm_we    = 1'b1;
          cm_waddr = open_chunk;
          cm_wdata = {SW'(0), NW'(2)};
        end
      end
      ST_ROOM: begin
        if (room) begin
          if (head_rd != '0) begin
            lm_re = 1'b1;
          end else begin
            cm_we    = 1'b1;
            cm_wdata = {SW'(0), fresh_inc};
          end
        end
      end
      ST_POP: begin
        cm_we    = 1'b1;
        cm_wdata = {link_rd, fresh_rd};
      end
      default: begin
      end
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      partial_map <= '0;
      chunks_open <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_chunk <= chunk_index;
            req_slot  <= slot_index;
          end
        end
        ST_FREE: begin
          done        <= 1'b1;
          status      <= free_ok ? STATUS_OK : STATUS_BAD_FREE;
          got_chunk   <= '0;
          got_slot    <= '0;
          byte_offset <= '0;
          if (free_ok) begin
            partial_map[req_chunk] <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (any_partial) begin
            pick <= low_pick;
          end else if (can_open) begin
            pick                    <= open_chunk;
            slot_r                  <= SW'(1);
            chunks_open             <= chunks_open + 1'b1;
            partial_map[open_chunk] <= keep_open;
          end else begin
            done        <= 1'b1;
            status      <= STATUS_OOM;
            got_chunk   <= '0;
            got_slot    <= '0;
            byte_offset <= '0;
          end
        end
        ST_ROOM: begin
          if (!room) begin
            partial_map[pick] <= 1'b0;
          end else if (head_rd == '0) begin
            slot_r            <= fresh_rd[SW-1:0];
            partial_map[pick] <= keep_fresh;
          end
        end
        ST_POP: begin
          slot_r            <= head_rd;
          partial_map[pick] <= keep_pop;
        end
        ST_MUL: begin
          prod <= PROD_W'(slot_r) * PROD_W'(eff);
        end
        ST_OUT: begin
          done        <= 1'b1;
          status      <= STATUS_OK;
          got_chunk   <= pick;
          got_slot    <= slot_r;
          byte_offset <= off_sum[OFFSET_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/soa_slot_div.sv =====
// ----------------------------------------------------------------------------
// soa_slot_div: slots-per-chunk calculator
// Restoring divider, one quotient bit per cycle: CHUNK_BYTES / divisor,
// clamped to MAX_SLOTS. Holds the last result until the next division ends.
// ----------------------------------------------------------------------------
module soa_slot_div #(
  parameter int CHUNK_BYTES = soa_pkg::DEF_CHUNK_BYTES,
  parameter int MAX_SLOTS   = soa_pkg::DEF_MAX_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic [soa_pkg::OBJ_W-1:0]          divisor,
  output logic                               busy,
  output logic [$clog2(MAX_SLOTS+1)-1:0]     slots
);
  import soa_pkg::*;

  localparam int DW = $clog2(CHUNK_BYTES + 1);
  localparam int CW = idx_w(DW);
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int RESET_Q = CHUNK_BYTES / 16;
  localparam int RESET_SLOTS = (RESET_Q > MAX_SLOTS) ? MAX_SLOTS : RESET_Q;
  localparam logic [DW-1:0] DIVIDEND = DW'(CHUNK_BYTES);

  logic              active;
  logic [CW-1:0]     cnt;
  logic [OBJ_W-1:0]  div_r;
  logic [OBJ_W:0]    rem;
  logic [DW-1:0]     quo;

  logic [OBJ_W:0]    shifted;
  logic              ge;
  logic [DW-1:0]     quo_next;

  assign shifted  = {rem[OBJ_W-1:0], DIVIDEND[cnt]};
  assign ge       = shifted >= {1'b0, div_r};
  assign quo_next = {quo[DW-2:0], ge};
  assign busy     = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      slots  <= NW'(RESET_SLOTS);
    end else if (go) begin
      active <= 1'b1;
      cnt    <= CW'(DW - 1);
      div_r  <= divisor;
      rem    <= '0;
      quo    <= '0;
    end else if (active) begin
      rem <= ge ? (shifted - {1'b0, div_r}) : shifted;
      quo <= quo_next;
      if (cnt == '0) begin
        active <= 1'b0;
        if (32'(quo_next) > 32'(MAX_SLOTS)) begin
          slots <= NW'(MAX_SLOTS);
        end else begin
          slots <= NW'(quo_next);
        end
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
